// ===== design/w2s_pkg.sv =====
// Shared constants for the world-to-screen projection pipeline.
`default_nettype none
package w2s_pkg;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAT_ENTRIES     = 32;
  localparam int ONE_Q           = 65536;
  localparam int CLIP_W_MIN      = 6554;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 14;
  localparam int SCREEN_W        = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = SCREEN_W'(1920);
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = SCREEN_W'(1080);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_POINT = 1'b1;
endpackage
`default_nettype wire

// ===== design/world_to_screen_projection.sv =====
// Throughput: one request per cycle unless a result waits on out_stall; a load waits while
//   a point in the first three stages still has to read the matrices.
// The divide runs one quotient bit per stage over VALUE_WIDTH + 16 stages.
// Reset: matrices clear to zero, viewport returns to 1920 x 1080, pipeline empties.
`default_nettype none
module world_to_screen_projection #(
  parameter int VALUE_WIDTH = w2s_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic                               in_matrix_select,
  input  logic [3:0]                         in_element_index,
  input  logic signed [31:0]                 in_element_value,
  input  logic signed [31:0]                 in_world_x,
  input  logic signed [31:0]                 in_world_y,
  input  logic signed [31:0]                 in_world_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_visible,
  output logic signed [31:0]                 out_screen_x,
  output logic signed [31:0]                 out_screen_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [w2s_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [w2s_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import w2s_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int NW  = W + 16;         // dividend width: |clip| << 16
  localparam int CPW = 32 + W;         // clip product width
  localparam int CSW = CPW + 2;        // clip sum width
  localparam int CFW = CSW - 16;       // clip sum after floor
  localparam int SPW = W + 16;         // screen product width

  localparam logic signed [49:0]    VMAX50 = (50'sd1 <<< (W - 1)) - 50'sd1;
  localparam logic signed [49:0]    VMIN50 = -(50'sd1 <<< (W - 1));
  localparam logic signed [CFW-1:0] VMAXC  = (CFW'(1) <<< (W - 1)) - CFW'(1);
  localparam logic signed [CFW-1:0] VMINC  = -(CFW'(1) <<< (W - 1));
  localparam logic signed [W-1:0]   VMAX   = VMAXC[W-1:0];
  localparam logic signed [W-1:0]   VMIN   = VMINC[W-1:0];
  localparam logic [NW-1:0]         QPOS   = (NW'(1) << (W - 1)) - NW'(1);
  localparam logic [NW-1:0]         QNEG   = NW'(1) << (W - 1);
  localparam logic signed [SPW-1:0] S32MAX = SPW'(32'sh7fffffff);
  localparam logic signed [SPW-1:0] S32MIN = SPW'($signed(32'h80000000));
  localparam logic signed [W-1:0]   WMIN   = W'(CLIP_W_MIN);
  localparam logic signed [W:0]     ONE_W  = (W + 1)'(ONE_Q);

  typedef struct packed {
    logic [W-1:0]  d;
    logic [W-1:0]  rx;
    logic [W-1:0]  ry;
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [NW-1:0] qx;
    logic [NW-1:0] qy;
    logic          sx;
    logic          sy;
    logic          fail;
    logic          front;
  } dv_t;

  // Global advance: the whole pipeline holds while a result waits downstream.
  logic en;
  logic in_acc;

  logic signed [31:0] mat_r [MAT_ENTRIES];
  logic [SCREEN_W-1:0] width_r, height_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, vn_r, vm_r, out_valid_r;
  logic signed [31:0] wx_r, wy_r, wz_r;
  logic signed [63:0] p2_r [4][4];
  logic signed [W-1:0] view_r [4];
  logic fail3_r;
  logic signed [CPW-1:0] p4_r [4][4];
  logic fail4_r;
  logic signed [W-1:0] clip_r [4];
  logic fail5_r;

  dv_t dv_r   [NW+1];
  logic dv_v_r [NW+1];

  logic signed [W-1:0] nx_r, ny_r;
  logic fail_n_r, front_n_r;
  logic signed [SPW-1:0] px_r, py_r;
  logic fail_m_r, front_m_r;
  logic out_visible_r;
  logic signed [31:0] out_screen_x_r, out_screen_y_r;

  assign en        = !(out_valid_r && out_stall);
  // Hold loads while a point ahead of the clip products still reads the store.
  assign in_stall  = !en || ((in_kind == KIND_LOAD) && (v1_r || v2_r || v3_r));
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RST;
      height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_data[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: height_r <= cfg_data[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Matrix store: view in entries 0..15, projection in 16..31, column major.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_ENTRIES; i++) mat_r[i] <= '0;
    end else if (in_acc && (in_kind == KIND_LOAD)) begin
      mat_r[{in_matrix_select, in_element_index}] <= in_element_value;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      dv_v_r[0] <= 1'b0; vn_r <= 1'b0; vm_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_acc && (in_kind == KIND_POINT);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      dv_v_r[0]   <= v5_r;
      vn_r        <= dv_v_r[NW];
      vm_r        <= vn_r;
      out_valid_r <= vm_r;
    end
  end

  // Stage 1: capture the world point.
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_world_x;
      wy_r <= in_world_y;
      wz_r <= in_world_z;
    end
  end

  // Stage 2: view products; w = 1.0 makes the last column a shift.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        p2_r[r][0] <= 64'(mat_r[r]) * 64'(wx_r);
        p2_r[r][1] <= 64'(mat_r[r + 4]) * 64'(wy_r);
        p2_r[r][2] <= 64'(mat_r[r + 8]) * 64'(wz_r);
        p2_r[r][3] <= {{16{mat_r[r + 12][31]}}, mat_r[r + 12], 16'h0000};
      end
    end
  end

  // Stage 3: sum, floor to Q16.16, saturate.
  logic signed [65:0] vsum [4];
  logic signed [49:0] vfl  [4];
  logic signed [W-1:0] view_nxt [4];
  logic fail3_nxt;
  always_comb begin
    fail3_nxt = 1'b0;
    for (int r = 0; r < 4; r++) begin
      vsum[r] = 66'(p2_r[r][0]) + 66'(p2_r[r][1]) + 66'(p2_r[r][2]) + 66'(p2_r[r][3]);
      vfl[r]  = vsum[r][65:16];
      if (vfl[r] > VMAX50) begin
        view_nxt[r] = VMAX;
        fail3_nxt   = 1'b1;
      end else if (vfl[r] < VMIN50) begin
        view_nxt[r] = VMIN;
        fail3_nxt   = 1'b1;
      end else begin
        view_nxt[r] = vfl[r][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      view_r  <= view_nxt;
      fail3_r <= fail3_nxt;
    end
  end

  // Stage 4: projection products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          p4_r[r][k] <= CPW'(mat_r[16 + r + 4 * k]) * CPW'(view_r[k]);
        end
      end
      fail4_r <= fail3_r;
    end
  end

  // Stage 5: clip sums.
  logic signed [CSW-1:0] csum [4];
  logic signed [CFW-1:0] cfl  [4];
  logic signed [W-1:0] clip_nxt [4];
  logic fail5_nxt;
  always_comb begin
    fail5_nxt = fail4_r;
    for (int r = 0; r < 4; r++) begin
      csum[r] = CSW'(p4_r[r][0]) + CSW'(p4_r[r][1]) + CSW'(p4_r[r][2]) + CSW'(p4_r[r][3]);
      cfl[r]  = csum[r][CSW-1:16];
      if (cfl[r] > VMAXC) begin
        clip_nxt[r] = VMAX;
        fail5_nxt   = 1'b1;
      end else if (cfl[r] < VMINC) begin
        clip_nxt[r] = VMIN;
        fail5_nxt   = 1'b1;
      end else begin
        clip_nxt[r] = cfl[r][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r  <= clip_nxt;
      fail5_r <= fail5_nxt;
    end
  end

  // Divider entry: magnitudes, signs, and the near-plane test.
  logic [W-1:0] magx, magy;
  assign magx = clip_r[0][W-1] ? W'(-clip_r[0]) : clip_r[0];
  assign magy = clip_r[1][W-1] ? W'(-clip_r[1]) : clip_r[1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0].d     <= clip_r[3];
      dv_r[0].rx    <= '0;
      dv_r[0].ry    <= '0;
      dv_r[0].nx    <= {magx, 16'h0000};
      dv_r[0].ny    <= {magy, 16'h0000};
      dv_r[0].qx    <= '0;
      dv_r[0].qy    <= '0;
      dv_r[0].sx    <= clip_r[0][W-1];
      dv_r[0].sy    <= clip_r[1][W-1];
      dv_r[0].fail  <= fail5_r;
      dv_r[0].front <= !(clip_r[3] < WMIN);
    end
  end

  // Restoring divide, one quotient bit per stage for x and y.
  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [W:0] shx, shy;
    logic gex, gey;
    dv_t div_nxt;
    always_comb begin
      div_nxt    = dv_r[j];
      shx        = {dv_r[j].rx, dv_r[j].nx[NW-1]};
      shy        = {dv_r[j].ry, dv_r[j].ny[NW-1]};
      gex        = shx >= {1'b0, dv_r[j].d};
      gey        = shy >= {1'b0, dv_r[j].d};
      div_nxt.rx = gex ? W'(shx - {1'b0, dv_r[j].d}) : shx[W-1:0];
      div_nxt.ry = gey ? W'(shy - {1'b0, dv_r[j].d}) : shy[W-1:0];
      div_nxt.qx = {dv_r[j].qx[NW-2:0], gex};
      div_nxt.qy = {dv_r[j].qy[NW-2:0], gey};
      div_nxt.nx = dv_r[j].nx << 1;
      div_nxt.ny = dv_r[j].ny << 1;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j + 1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j + 1] <= dv_v_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[j + 1] <= div_nxt;
    end
  end

  // NDC: restore sign and saturate the quotient.
  logic signed [W-1:0] nx_nxt, ny_nxt;
  logic fail_n_nxt;
  always_comb begin
    fail_n_nxt = dv_r[NW].fail;
    if (!dv_r[NW].sx) begin
      if (dv_r[NW].qx > QPOS) begin
        nx_nxt = VMAX; fail_n_nxt = 1'b1;
      end else begin
        nx_nxt = dv_r[NW].qx[W-1:0];
      end
    end else if (dv_r[NW].qx > QNEG) begin
      nx_nxt = VMIN; fail_n_nxt = 1'b1;
    end else begin
      nx_nxt = W'(-dv_r[NW].qx[W-1:0]);
    end
    if (!dv_r[NW].sy) begin
      if (dv_r[NW].qy > QPOS) begin
        ny_nxt = VMAX; fail_n_nxt = 1'b1;
      end else begin
        ny_nxt = dv_r[NW].qy[W-1:0];
      end
    end else if (dv_r[NW].qy > QNEG) begin
      ny_nxt = VMIN; fail_n_nxt = 1'b1;
    end else begin
      ny_nxt = W'(-dv_r[NW].qy[W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r      <= nx_nxt;
      ny_r      <= ny_nxt;
      fail_n_r  <= fail_n_nxt;
      front_n_r <= dv_r[NW].front;
    end
  end

  // Viewport scale: x grows right, y flipped.
  logic signed [W:0] ax, ay;
  logic signed [14:0] swid, shgt;
  assign ax   = (W + 1)'(nx_r) + ONE_W;
  assign ay   = ONE_W - (W + 1)'(ny_r);
  assign swid = {1'b0, width_r};
  assign shgt = {1'b0, height_r};

  always_ff @(posedge clk) begin
    if (en) begin
      px_r      <= SPW'(ax) * SPW'(swid);
      py_r      <= SPW'(ay) * SPW'(shgt);
      fail_m_r  <= fail_n_r;
      front_m_r <= front_n_r;
    end
  end

  // Halve with floor, clamp to 32 bits, drop rejected points to zero.
  logic signed [SPW-1:0] hx, hy;
  logic signed [31:0] sx_sat, sy_sat;
  logic fail_o, zero_vp;
  always_comb begin
    hx     = px_r >>> 1;
    hy     = py_r >>> 1;
    fail_o = fail_m_r;
    if (hx > S32MAX) begin
      sx_sat = 32'sh7fffffff; fail_o = 1'b1;
    end else if (hx < S32MIN) begin
      sx_sat = $signed(32'h80000000); fail_o = 1'b1;
    end else begin
      sx_sat = hx[31:0];
    end
    if (hy > S32MAX) begin
      sy_sat = 32'sh7fffffff; fail_o = 1'b1;
    end else if (hy < S32MIN) begin
      sy_sat = $signed(32'h80000000); fail_o = 1'b1;
    end else begin
      sy_sat = hy[31:0];
    end
    zero_vp = (width_r == '0) || (height_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_vp || !front_m_r) begin
        out_visible_r  <= 1'b0;
        out_screen_x_r <= '0;
        out_screen_y_r <= '0;
      end else begin
        out_visible_r  <= !fail_o;
        out_screen_x_r <= sx_sat;
        out_screen_y_r <= sy_sat;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = out_visible_r;
  assign out_screen_x = out_screen_x_r;
  assign out_screen_y = out_screen_y_r;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for world_to_screen_projection: predicts each projected point and checks results.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import w2s_pkg::*;

  localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 90;    // pipeline depth plus margin
  localparam int LONG_HOLD    = 400;   // receiver hold-off for the pressure test

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } screen_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_LOAD;
  logic in_matrix_select = 1'b0;
  logic [3:0] in_element_index = '0;
  logic signed [31:0] in_element_value = '0;
  logic signed [31:0] in_world_x = '0;
  logic signed [31:0] in_world_y = '0;
  logic signed [31:0] in_world_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_visible;
  logic signed [31:0] out_screen_x;
  logic signed [31:0] out_screen_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  world_to_screen_projection uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block's state: matrices (view at 0..15, projection at 16..31)
  // and the viewport size.
  logic [31:0] matrix_shadow [MAT_ENTRIES];
  int unsigned view_width;
  int unsigned view_height;

  screen_point_t expected_points[$];
  int error_count = 0;
  int stall_pct = 0;        // receiver stall rate, in percent
  int gap_max = 0;          // longest sender gap between bursts
  bit hold_request = 1'b0;  // ask the receiver for one long hold-off
  int hold_left = 0;
  int idle_cycles = 0;
  int points_sent = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic signed [63:0] saturate32(input logic signed [127:0] v,
                                                    inout bit failed);
    if (v > 128'sd2147483647) begin
      failed = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      failed = 1'b1;
      return -64'sd2147483648;
    end
    return v[63:0];
  endfunction

  // One row of a column-major matrix times a Q16.16 vector, floored and saturated.
  function automatic logic signed [63:0] matrix_row(input int base, input int row,
                                                    input logic signed [63:0] vec [4],
                                                    inout bit failed);
    logic signed [127:0] acc;
    logic signed [127:0] elem;
    logic signed [127:0] comp;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      elem = $signed(matrix_shadow[base + row + 4 * k]);
      comp = vec[k];
      acc = acc + elem * comp;
    end
    return saturate32(acc >>> 16, failed);
  endfunction

  function automatic logic signed [63:0] divide_by_w(input logic signed [63:0] c,
                                                     input logic signed [63:0] w,
                                                     inout bit failed);
    logic [63:0] mag;
    logic signed [127:0] q;
    mag = (c < 0) ? -c : c;
    q = $signed({64'd0, (mag << 16) / w});
    if (c < 0) q = -q;
    return saturate32(q, failed);
  endfunction

  function automatic screen_point_t project_point(input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] z);
    screen_point_t res;
    logic signed [63:0] world [4];
    logic signed [63:0] eye [4];
    logic signed [63:0] clip [4];
    logic signed [63:0] ndc_x, ndc_y;
    logic signed [127:0] sx, sy;
    bit failed;
    res = '0;
    failed = 1'b0;
    if (view_width == 0 || view_height == 0) return res;
    world[0] = x;
    world[1] = y;
    world[2] = z;
    world[3] = ONE_Q;
    for (int r = 0; r < 4; r++) eye[r] = matrix_row(0, r, world, failed);
    for (int r = 0; r < 4; r++) clip[r] = matrix_row(16, r, eye, failed);
    if (clip[3] < CLIP_W_MIN) return res;
    ndc_x = divide_by_w(clip[0], clip[3], failed);
    ndc_y = divide_by_w(clip[1], clip[3], failed);
    sx = ((128'(ndc_x) + ONE_Q) * $signed({96'd0, view_width})) >>> 1;
    sy = ((128'sd65536 - ndc_y) * $signed({96'd0, view_height})) >>> 1;
    res.screen_x = saturate32(sx, failed);
    res.screen_y = saturate32(sy, failed);
    res.visible  = !failed;
    return res;
  endfunction

  // Offer one request and hold it until accepted; update the shadow on acceptance.
  task automatic send_request(input logic kind, input logic sel, input logic [3:0] idx,
                              input logic [31:0] value, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
    int gap;
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_matrix_select <= sel;
    in_element_index <= idx;
    in_element_value <= value;
    in_world_x       <= x;
    in_world_y       <= y;
    in_world_z       <= z;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_LOAD) begin
      matrix_shadow[{sel, idx}] = value;
    end else begin
      expected_points.push_back(project_point(x, y, z));
      points_sent++;
    end
    // Gaps fall between bursts of random length.
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_element(input logic sel, input logic [3:0] idx,
                              input logic [31:0] value);
    send_request(KIND_LOAD, sel, idx, value, $urandom, $urandom, $urandom);
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    send_request(KIND_POINT, $urandom, $urandom, $urandom, x, y, z);
  endtask

  // Let every expected result arrive, then let a trailing load settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) view_width = data;
    else if (idx == CFG_SCREEN_HEIGHT) view_height = data;
  endtask

  function automatic logic [31:0] rand_q(input int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Plausible camera: random view near identity, perspective whose clip w is view z plus sparse random terms.
  task automatic load_camera();
    for (int i = 0; i < 16; i++) begin
      if (i == 15) load_element(1'b0, 4'(i), ONE_Q);
      else if (i % 5 == 0) load_element(1'b0, 4'(i), ONE_Q + rand_q(ONE_Q / 2));
      else if (i >= 12) load_element(1'b0, 4'(i), rand_q(50 * ONE_Q));
      else load_element(1'b0, 4'(i), rand_q(ONE_Q / 4));
    end
    for (int i = 0; i < 16; i++) begin
      case (i)
        0, 5:    load_element(1'b1, 4'(i), rand_q(4 * ONE_Q));
        10, 14:  load_element(1'b1, 4'(i), rand_q(2 * ONE_Q));
        11:      load_element(1'b1, 4'(i), ONE_Q);
        default: load_element(1'b1, 4'(i), ($urandom_range(0, 3) == 0) ? rand_q(ONE_Q) : 0);
      endcase
    end
  endtask

  // Fresh matrices are all zero, so clip w is zero and every point is rejected.
  task automatic test_cleared_matrices();
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
    send_point(rand_q(100 * ONE_Q), rand_q(100 * ONE_Q), rand_q(100 * ONE_Q));
    wait_drained();
  endtask

  // Identity camera: check extremes, the near-w threshold, and overflow saturation.
  task automatic test_directed_cases();
    for (int i = 0; i < 16; i++) begin
      load_element(1'b0, 4'(i), (i % 5 == 0) ? ONE_Q : 0);
    end
    for (int i = 0; i < 16; i++) begin
      load_element(1'b1, 4'(i), (i == 0 || i == 5 || i == 10 || i == 11) ? ONE_Q : 0);
    end
    send_point(0, 0, ONE_Q);               // center of the screen
    send_point(ONE_Q, -ONE_Q, ONE_Q);      // corner
    send_point(0, 0, 6553);                // just below the near threshold
    send_point(0, 0, 6554);                // at the threshold
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 6554);  // divide overflow
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(0, 0, 32'sh8000_0000);      // behind the camera
    load_element(1'b1, 4'd0, 32'sh7FFF_FFFF);          // huge product into clip x
    load_element(1'b0, 4'd12, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 0, ONE_Q);
    wait_drained();
  endtask

  // Sweep viewport extremes, zero size, and ignored register indexes.
  task automatic test_viewport_settings();
    logic [CFG_DATA_W-1:0] widths [6] = '{1, 8192, 16383, 0, 640, 1920};
    logic [CFG_DATA_W-1:0] heights [6] = '{8192, 1, 16383, 480, 0, 1080};
    load_camera();
    for (int s = 0; s < 6; s++) begin
      write_register(CFG_SCREEN_WIDTH, widths[s]);
      write_register(CFG_SCREEN_HEIGHT, heights[s]);
      write_register(CFG_IDX_W'(2 + $urandom_range(0, 13)), $urandom);
      for (int p = 0; p < 8; p++) begin
        send_point(rand_q(30 * ONE_Q), rand_q(30 * ONE_Q), rand_q(200 * ONE_Q));
      end
    end
    wait_drained();
  endtask

  // Mostly well-formed camera loads followed by point streams; some noise.
  task automatic test_random_streams(input int target);
    while (points_sent < target) begin
      stall_pct = $urandom_range(0, 3) * 25;
      gap_max   = $urandom_range(0, 2) * 4;
      if ($urandom_range(0, 9) < 8) load_camera();
      else begin
        repeat ($urandom_range(1, 10)) load_element($urandom, $urandom, $urandom);
      end
      repeat ($urandom_range(5, 40)) begin
        if ($urandom_range(0, 9) == 0) send_point($urandom, $urandom, $urandom);
        else send_point(rand_q(60 * ONE_Q), rand_q(60 * ONE_Q), rand_q(300 * ONE_Q));
      end
      if ($urandom_range(0, 5) == 0) begin
        write_register(CFG_SCREEN_WIDTH, $urandom_range(1, 8192));
        write_register(CFG_SCREEN_HEIGHT, $urandom_range(1, 8192));
      end
    end
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps going, so the pipeline backs up.
  task automatic test_backpressure();
    stall_pct = 0;
    gap_max = 0;
    hold_request = 1'b1;
    repeat (150) send_point(rand_q(20 * ONE_Q), rand_q(20 * ONE_Q), rand_q(100 * ONE_Q));
    wait_drained();
  endtask

  // Receiver: check each accepted result, then pick the stall for the next edge.
  always @(posedge clk) begin
    screen_point_t want;
    if (out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("[%0t] unexpected result", $realtime);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (out_visible !== want.visible)
          report_mismatch("visible", out_visible, want.visible);
        if (out_screen_x !== want.screen_x)
          report_mismatch("screen_x", out_screen_x, want.screen_x);
        if (out_screen_y !== want.screen_y)
          report_mismatch("screen_y", out_screen_y, want.screen_y);
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: any handshake resets the idle count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAT_ENTRIES; i++) matrix_shadow[i] = '0;
    view_width  = SCREEN_WIDTH_RST;
    view_height = SCREEN_HEIGHT_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cleared_matrices();
    test_directed_cases();
    test_viewport_settings();
    test_backpressure();
    test_random_streams(400);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
